>>> rtl/core/multimode_pi_motor_control_core_macros.svh
// assertion macros for the multimode pi motor control core
// used by the checker module, no other dependencies
`ifndef MULTIMODE_PI_MOTOR_CONTROL_CORE_MACROS_SVH
`define MULTIMODE_PI_MOTOR_CONTROL_CORE_MACROS_SVH

// property checked outside reset
`define MPMC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define MPMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mpmc_pkg.sv
// shared types and constants for the multimode pi motor control core
// no dependencies
`timescale 1ns / 1ps

package mpmc_pkg;

    // control modes
    localparam logic [1:0] MODE_CURRENT  = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;
    localparam logic [1:0] MODE_SPEED    = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_CUR_LIMIT = 2'd1;
    localparam logic [1:0] REG_MARGIN    = 2'd2;
    localparam logic [1:0] REG_DRV_LIMIT = 2'd3;

    // q8 gains
    localparam logic [7:0] GAIN_P_CURRENT  = 8'd102;
    localparam logic [7:0] GAIN_I_CURRENT  = 8'd26;
    localparam logic [7:0] GAIN_P_POSITION = 8'd230;
    localparam logic [7:0] GAIN_I_POSITION = 8'd26;
    localparam logic [7:0] GAIN_P_SPEED    = 8'd102;
    localparam logic [7:0] GAIN_I_SPEED    = 8'd18;

    localparam int ANGLE_TOLERANCE_DEF = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  cur_limit;
        logic [6:0]  margin;
        logic [14:0] drv_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:      MODE_CURRENT,
        cur_limit: 10'd512,
        margin:    7'd10,
        drv_limit: 15'd255
    };

    typedef struct packed {
        logic               command;
        logic signed [15:0] setpoint_value;
        logic [9:0]         measured_current;
        logic [8:0]         measured_angle;
        logic signed [15:0] measured_speed;
    } t_item;

    typedef struct packed {
        logic signed [15:0] held;
        logic signed [15:0] prev;
        logic signed [15:0] int_cur;
        logic signed [15:0] int_pos;
        logic signed [15:0] int_spd;
    } t_state;

endpackage

>>> rtl/core/mpmc_if.sv
// valid/ready channel interfaces for the multimode pi motor control core
// no dependencies
`timescale 1ns / 1ps

interface mpmc_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [15:0] setpoint_value;
    logic [9:0]         measured_current;
    logic [8:0]         measured_angle;
    logic signed [15:0] measured_speed;

    modport source (
        output valid, command, setpoint_value, measured_current,
               measured_angle, measured_speed,
        input  ready
    );
    modport sink (
        input  valid, command, setpoint_value, measured_current,
               measured_angle, measured_speed,
        output ready
    );
endinterface

interface mpmc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] drive;
    logic               setpoint_replaced;

    modport source (
        output valid, drive, setpoint_replaced,
        input  ready
    );
    modport sink (
        input  valid, drive, setpoint_replaced,
        output ready
    );
endinterface

>>> rtl/core/multimode_pi_motor_control_core.sv
// a control tick is registered in the input stage, then its result in the result register
// throughput: one word per cycle while the result slot is free, set by the combinational regulator datapath
// a setpoint load passes through the input stage and gives no result
// reset (synchronous, active low) clears valids, setpoint and integrators,
// and restores the register defaults
`timescale 1ns / 1ps

module multimode_pi_motor_control_core
    import mpmc_pkg::*;
#(
    parameter int P_ANGLE_TOLERANCE = ANGLE_TOLERANCE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mpmc_in_if.sink      i_in_if,
    mpmc_out_if.source   o_out_if,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // register file
    t_cfg               r_cfg;

    // regulator state, written once per word leaving the input stage
    t_state             r_state;
    t_state             n_state;

    // input stage
    logic               r_s1_v;
    t_item              r_s1;

    // result register
    logic               r_out_v;
    logic signed [15:0] r_out_drive;
    logic               r_out_repl;

    logic               calc_result;
    logic signed [15:0] calc_drive;
    logic               calc_repl;

    logic               out_free;
    logic               advance;
    logic               in_ready;
    logic               cfg_wr;

    // a setpoint load leaves the input stage without needing the result slot
    assign out_free = !r_out_v || o_out_if.ready;
    assign advance  = r_s1_v && (r_s1.command || out_free);
    assign in_ready = !r_s1_v || advance;
    assign i_in_if.ready = in_ready;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    mpmc_pi_calc #(
        .P_ANGLE_TOLERANCE (P_ANGLE_TOLERANCE)
    ) u_calc (
        .i_cfg      (r_cfg),
        .i_item     (r_s1),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_result   (calc_result),
        .o_drive    (calc_drive),
        .o_replaced (calc_repl)
    );

    // control, configuration and regulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_cfg   <= CFG_RESET;
            r_state <= '0;
        end else begin
            if (in_ready) begin
                r_s1_v <= i_in_if.valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
            if (advance && calc_result) begin
                r_out_v <= 1'b1;
            end else if (o_out_if.ready) begin
                r_out_v <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_MODE: begin
                        // the unused mode code is dropped
                        if (pwdata[1:0] != MODE_UNUSED) begin
                            r_cfg.mode <= pwdata[1:0];
                        end
                    end
                    REG_CUR_LIMIT: r_cfg.cur_limit <= pwdata[9:0];
                    REG_MARGIN:    r_cfg.margin    <= pwdata[6:0];
                    REG_DRV_LIMIT: r_cfg.drv_limit <= pwdata[14:0];
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_if.valid && in_ready) begin
            r_s1.command          <= i_in_if.command;
            r_s1.setpoint_value   <= i_in_if.setpoint_value;
            r_s1.measured_current <= i_in_if.measured_current;
            r_s1.measured_angle   <= i_in_if.measured_angle;
            r_s1.measured_speed   <= i_in_if.measured_speed;
        end
        if (advance && calc_result) begin
            r_out_drive <= calc_drive;
            r_out_repl  <= calc_repl;
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:      prdata = {30'b0, r_cfg.mode};
            REG_CUR_LIMIT: prdata = {22'b0, r_cfg.cur_limit};
            REG_MARGIN:    prdata = {25'b0, r_cfg.margin};
            REG_DRV_LIMIT: prdata = {17'b0, r_cfg.drv_limit};
        endcase
    end

    assign o_out_if.valid             = r_out_v;
    assign o_out_if.drive             = r_out_drive;
    assign o_out_if.setpoint_replaced = r_out_repl;

endmodule

>>> rtl/core/mpmc_pi_calc.sv
// per-word regulator datapath: errors, q8 products, integrators, clamp
// depends on mpmc_pkg
`timescale 1ns / 1ps

module mpmc_pi_calc
    import mpmc_pkg::*;
#(
    parameter int P_ANGLE_TOLERANCE = ANGLE_TOLERANCE_DEF
) (
    input  t_cfg               i_cfg,
    input  t_item              i_item,
    input  t_state             i_state,
    output t_state             o_state,
    output logic               o_result,
    output logic signed [15:0] o_drive,
    output logic               o_replaced
);

    localparam logic signed [16:0] TOL = 17'(P_ANGLE_TOLERANCE);

    // gain * x / 256, truncated toward zero
    function automatic logic signed [17:0] q8mul(input logic [7:0] g,
                                                 input logic signed [16:0] x);
        logic signed [25:0] p;
        p = $signed({1'b0, g}) * x;
        if (p < 0) begin
            p = p + 26'sd255;
        end
        return p[25:8];
    endfunction

    function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
        return $signed({v[15], v});
    endfunction

    // integrator plus error, saturated to int16
    function automatic logic signed [15:0] acc16(input logic signed [15:0] a,
                                                 input logic signed [16:0] e);
        logic signed [17:0] s;
        s = $signed({a[15], a[15], a}) + $signed({e[16], e});
        if (s > 18'sd32767) begin
            return 16'sh7fff;
        end else if (s < -18'sd32768) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    function automatic logic signed [18:0] pi_sum(input logic signed [17:0] p,
                                                  input logic signed [17:0] i);
        return $signed({p[17], p}) + $signed({i[17], i});
    endfunction

    logic signed [16:0] target;
    logic signed [16:0] cur;
    logic signed [16:0] err_cur;
    logic signed [16:0] err_raw;
    logic signed [16:0] err_pos;
    logic signed [16:0] err_spd;
    logic signed [15:0] held_spd;
    logic signed [15:0] ip_eff;
    logic signed [15:0] is_eff;
    logic               at_limit;
    logic signed [18:0] sum;
    logic signed [18:0] lim;

    always_comb begin
        target   = $signed({7'b0, i_cfg.cur_limit}) - $signed({10'b0, i_cfg.margin});
        cur      = $signed({7'b0, i_item.measured_current});
        err_cur  = target - cur;

        // angle error wrapped once into +-180
        err_raw  = sx17(i_state.held) - $signed({8'b0, i_item.measured_angle});
        if (err_raw > 17'sd180) begin
            err_pos = err_raw - 17'sd360;
        end else if (err_raw < -17'sd180) begin
            err_pos = err_raw + 17'sd360;
        end else begin
            err_pos = err_raw;
        end
        ip_eff   = (i_state.prev != i_state.held) ? 16'sd0 : i_state.int_pos;

        // speed mode: current at limit takes the measured speed as setpoint
        at_limit = (cur >= target);
        held_spd = at_limit ? i_item.measured_speed : i_state.held;
        err_spd  = sx17(held_spd) - sx17(i_item.measured_speed);
        is_eff   = (i_state.held == 16'sd0) ? 16'sd0 : i_state.int_spd;
    end

    always_comb begin
        o_state    = i_state;
        o_replaced = 1'b0;
        o_result   = !i_item.command;
        sum        = '0;
        if (i_item.command) begin
            o_state.held = i_item.setpoint_value;
        end else begin
            unique case (i_cfg.mode)
                MODE_CURRENT: begin
                    if (i_state.held != 16'sd0) begin
                        sum = pi_sum(q8mul(GAIN_P_CURRENT, err_cur),
                                     q8mul(GAIN_I_CURRENT, sx17(i_state.int_cur)));
                        if (i_state.held < 0) begin
                            sum = -sum;
                        end
                        o_state.int_cur = acc16(i_state.int_cur, err_cur);
                    end else begin
                        o_state.int_cur = '0;
                    end
                end
                MODE_POSITION: begin
                    if (err_pos > TOL || err_pos < -TOL) begin
                        sum = pi_sum(q8mul(GAIN_P_POSITION, err_pos),
                                     q8mul(GAIN_I_POSITION, sx17(ip_eff)));
                        o_state.int_pos = acc16(ip_eff, err_pos);
                    end else begin
                        o_state.int_pos = '0;
                    end
                    o_state.prev = i_state.held;
                end
                default: begin
                    o_state.held    = held_spd;
                    o_replaced      = at_limit;
                    sum             = pi_sum(q8mul(GAIN_P_SPEED, err_spd),
                                             q8mul(GAIN_I_SPEED, sx17(is_eff)));
                    o_state.int_spd = acc16(is_eff, err_spd);
                end
            endcase
        end
    end

    // symmetric clamp to drive_limit
    always_comb begin
        lim = $signed({4'b0, i_cfg.drv_limit});
        if (sum > lim) begin
            o_drive = lim[15:0];
        end else if (sum < -lim) begin
            o_drive = -lim[15:0];
        end else begin
            o_drive = sum[15:0];
        end
    end

endmodule

>>> rtl/core/mpmc_checker.sv
// port-level checks for the multimode pi motor control core, with its bind
// depends on the macros header and the top level
`timescale 1ns / 1ps
`include "multimode_pi_motor_control_core_macros.svh"

module mpmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_drive,
    input logic        i_replaced
);

    // a stalled result keeps its valid and its payload
    `MPMC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `MPMC_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_drive) && $stable(i_replaced), "result changed while stalled")

    // clamp is symmetric, so the most negative code never appears
    `MPMC_ASSERT(a_drive_range, i_clk, i_rst_n, i_out_valid |-> i_drive != 16'h8000, "drive outside symmetric range")

    // reset empties the result register
    `MPMC_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind multimode_pi_motor_control_core mpmc_checker u_mpmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_if.valid),
    .i_out_ready (o_out_if.ready),
    .i_drive     (o_out_if.drive),
    .i_replaced  (o_out_if.setpoint_replaced)
);
